// File: sv/bfv_pkg.sv
// Shared types and constants of the block floating point vector ALU.
// Used by every module of the block; depends on nothing.
package bfv_pkg;

  // Renormalized results carry the magnitude MSB at this bit index.
  localparam int NORM_MSB = 13;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Request codes as they arrive on the req_type field.
  typedef enum logic [2:0] {
    REQ_ADD     = 3'd0,
    REQ_SUB     = 3'd1,
    REQ_SCALE   = 3'd2,
    REQ_EQUAL   = 3'd3,
    REQ_CONVERT = 3'd4
  } req_code_t;

  // Classes of work that the back part carries out.
  typedef enum logic [2:0] {
    K_NONE,
    K_ADDSUB,
    K_SCALE,
    K_EQUAL,
    K_CONVERT
  } kind_t;

  // Classified transaction as it is held in the queue. The "shf" operand
  // is the one that gets shifted, the "fix" operand stays put.
  typedef struct packed {
    kind_t              kind;
    logic               sub;
    logic               shf_first;
    logic               right;
    logic [4:0]         sh;
    logic signed [15:0] shf_x;
    logic signed [15:0] shf_y;
    logic signed [15:0] fix_x;
    logic signed [15:0] fix_y;
    logic signed [8:0]  bbp;
  } dec_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: sv/bfv_req_if.sv
// Request channel of the block floating point vector ALU.
// Carries valid, ready and the operand fields; no dependencies.
interface bfv_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic signed [7:0]  a_bbp;
  logic signed [15:0] b_x;
  logic signed [15:0] b_y;
  logic signed [7:0]  b_bbp;

  modport source (output valid, req_type, a_x, a_y, a_bbp, b_x, b_y, b_bbp,
                  input ready);
  modport sink (input valid, req_type, a_x, a_y, a_bbp, b_x, b_y, b_bbp,
                output ready);
endinterface

// File: sv/bfv_rsp_if.sv
// Response channel of the block floating point vector ALU.
// Carries valid, ready and the result fields; no dependencies.
interface bfv_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] r_x;
  logic signed [15:0] r_y;
  logic signed [7:0]  r_bbp;
  logic               is_equal;

  modport source (output valid, r_x, r_y, r_bbp, is_equal, input ready);
  modport sink (input valid, r_x, r_y, r_bbp, is_equal, output ready);
endinterface

// File: sv/bfv_front.sv
// Front part: accepts request transactions and classifies them.
// Depends on bfv_pkg and bfv_req_if.
module bfv_front
  import bfv_pkg::*;
(
  bfv_req_if.sink  req,
  input  q_stat_t  qstat,
  output logic     push,
  output dec_t     dec
);

  logic signed [8:0] d;
  logic signed [8:0] nd;
  logic              d_pos;
  logic [8:0]        mag;

  assign req.ready = !qstat.full;
  assign push      = req.valid && req.ready;

  always_comb begin
    d     = $signed({req.a_bbp[7], req.a_bbp}) - $signed({req.b_bbp[7], req.b_bbp});
    nd    = -d;
    d_pos = !d[8] && (d != 9'sd0);
    mag   = d_pos ? d : nd;

    dec           = '0;
    dec.kind      = K_NONE;
    dec.sh        = (mag > 9'd31) ? 5'd31 : mag[4:0];
    dec.shf_first = !d_pos;
    // The operand at the smaller bbp is brought up to the larger one.
    if (d_pos) begin
      dec.shf_x = req.b_x;
      dec.shf_y = req.b_y;
      dec.fix_x = req.a_x;
      dec.fix_y = req.a_y;
      dec.bbp   = $signed({req.a_bbp[7], req.a_bbp});
    end else begin
      dec.shf_x = req.a_x;
      dec.shf_y = req.a_y;
      dec.fix_x = req.b_x;
      dec.fix_y = req.b_y;
      dec.bbp   = $signed({req.b_bbp[7], req.b_bbp});
    end

    case (req.req_type)
      REQ_ADD, REQ_SUB: begin
        dec.kind = K_ADDSUB;
        dec.sub  = (req.req_type == REQ_SUB);
      end
      REQ_SCALE: begin
        dec.kind  = K_SCALE;
        dec.fix_x = req.a_x;
        dec.fix_y = req.a_y;
        dec.shf_x = req.b_x;
        dec.shf_y = req.b_x;
        dec.bbp   = $signed({req.a_bbp[7], req.a_bbp})
                  + $signed({req.b_bbp[7], req.b_bbp});
      end
      REQ_EQUAL: begin
        dec.kind = K_EQUAL;
      end
      REQ_CONVERT: begin
        dec.kind  = K_CONVERT;
        dec.shf_x = req.a_x;
        dec.shf_y = req.a_y;
        dec.right = d_pos;
        dec.bbp   = $signed({req.b_bbp[7], req.b_bbp});
      end
      default: begin
        dec.kind = K_NONE;
      end
    endcase
  end

endmodule

// File: sv/bfv_queue.sv
// Short queue of classified transactions between the front and the back.
// Depends on bfv_pkg.
module bfv_queue
  import bfv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  dec_t    din,
  input  logic    pop,
  output dec_t    dout,
  output q_stat_t stat
);

  dec_t               entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic [Q_PTR_W-1:0] wr_ptr_next;
  logic [Q_PTR_W-1:0] rd_ptr_next;
  logic [Q_CNT_W-1:0] count_next;

  assign stat.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count == '0);
  assign dout       = entry[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

endmodule

// File: sv/bfv_back.sv
// Back part: arithmetic, magnitude, MSB search and renormalization stages.
// Depends on bfv_pkg and bfv_rsp_if.
module bfv_back
  import bfv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  output logic     pop,
  input  dec_t     dec,
  bfv_rsp_if.source rsp
);

  typedef struct packed {
    kind_t              kind;
    logic               eq;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [8:0]  bbp;
  } s1_t;

  typedef struct packed {
    s1_t         base;
    logic        zero;
    logic [31:0] mag;
  } s2_t;

  typedef struct packed {
    s1_t        base;
    logic       zero;
    logic [4:0] msb;
  } s3_t;

  function automatic logic signed [31:0] sext16(logic signed [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Arithmetic right shift by amt, then add one and drop one more bit.
  function automatic logic [15:0] rnd_right(logic signed [31:0] v, logic [4:0] amt);
    logic signed [32:0] t;
    t = $signed({v[31], v}) >>> amt;
    t = t + 33'sd1;
    t = t >>> 1;
    return t[15:0];
  endfunction

  function automatic logic [15:0] shl16(logic [15:0] v, logic [4:0] amt);
    return v << amt;
  endfunction

  function automatic logic [4:0] msb_of(logic [31:0] m);
    logic [31:0] v;
    logic [4:0]  p;
    v = m;
    p = '0;
    if (v[31:16] != '0) begin p[4] = 1'b1; v = v >> 16; end
    if (v[15:8] != '0) begin p[3] = 1'b1; v = v >> 8; end
    if (v[7:4] != '0) begin p[2] = 1'b1; v = v >> 4; end
    if (v[3:2] != '0) begin p[1] = 1'b1; v = v >> 2; end
    if (v[1]) begin p[0] = 1'b1; end
    return p;
  endfunction

  logic v1, v2, v3, vo;
  logic adv1, adv2, adv3, adv_o;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  s3_t  s3, s3_next;
  logic signed [15:0] r_x, r_y, r_x_next, r_y_next;
  logic signed [7:0]  r_bbp, r_bbp_next;
  logic               is_equal, is_equal_next;

  // Stage 1 working signals.
  logic signed [31:0] shf32_x, shf32_y, fix32_x, fix32_y, shl_x, shl_y;
  logic signed [31:0] prod_x, prod_y;
  // Output stage working signals.
  logic signed [6:0]  sft;
  logic signed [9:0]  rb_w;
  logic signed [7:0]  rb_sat;
  logic [15:0]        nx, ny;

  assign adv_o = !vo || rsp.ready;
  assign adv3  = !v3 || adv_o;
  assign adv2  = !v2 || adv3;
  assign adv1  = !v1 || adv2;
  assign pop   = !q_empty && adv1;

  // Stage 1: alignment, add or subtract, multiply, compare, convert.
  always_comb begin
    shf32_x = sext16(dec.shf_x);
    shf32_y = sext16(dec.shf_y);
    fix32_x = sext16(dec.fix_x);
    fix32_y = sext16(dec.fix_y);
    shl_x   = shf32_x <<< dec.sh;
    shl_y   = shf32_y <<< dec.sh;
    prod_x  = fix32_x * shf32_x;
    prod_y  = fix32_y * shf32_x;

    s1_next      = '0;
    s1_next.kind = dec.kind;
    s1_next.bbp  = dec.bbp;
    case (dec.kind)
      K_ADDSUB: begin
        if (!dec.sub) begin
          s1_next.x = shl_x + fix32_x;
          s1_next.y = shl_y + fix32_y;
        end else if (dec.shf_first) begin
          s1_next.x = shl_x - fix32_x;
          s1_next.y = shl_y - fix32_y;
        end else begin
          s1_next.x = fix32_x - shl_x;
          s1_next.y = fix32_y - shl_y;
        end
      end
      K_SCALE: begin
        s1_next.x = prod_x;
        s1_next.y = prod_y;
      end
      K_EQUAL: begin
        // Exact: the shifted value must match and must shift back unchanged.
        s1_next.eq = (fix32_x == shl_x) && ((shl_x >>> dec.sh) == shf32_x)
                  && (fix32_y == shl_y) && ((shl_y >>> dec.sh) == shf32_y);
      end
      K_CONVERT: begin
        if (dec.right) begin
          s1_next.x = sext16(rnd_right(shf32_x, dec.sh - 5'd1));
          s1_next.y = sext16(rnd_right(shf32_y, dec.sh - 5'd1));
        end else begin
          s1_next.x = sext16(shl16(dec.shf_x, dec.sh));
          s1_next.y = sext16(shl16(dec.shf_y, dec.sh));
        end
      end
      default: begin
        s1_next.kind = K_NONE;
      end
    endcase
  end

  // Stage 2: zero detect and combined magnitude of both lanes.
  always_comb begin
    s2_next.base = s1;
    s2_next.zero = (s1.x == 32'sd0) && (s1.y == 32'sd0);
    s2_next.mag  = (s1.x[31] ? 32'(-s1.x) : 32'(s1.x))
                 | (s1.y[31] ? 32'(-s1.y) : 32'(s1.y));
  end

  // Stage 3: MSB index of the larger magnitude.
  always_comb begin
    s3_next.base = s2.base;
    s3_next.zero = s2.zero;
    s3_next.msb  = msb_of(s2.mag);
  end

  // Output stage: renormalize and select the result by class.
  always_comb begin
    sft  = $signed({2'b00, s3.msb}) - $signed(7'(NORM_MSB));
    rb_w = $signed({{1{s3.base.bbp[8]}}, s3.base.bbp}) - $signed({{3{sft[6]}}, sft});
    if (rb_w > 10'sd127) begin
      rb_sat = 8'sd127;
    end else if (rb_w < -10'sd128) begin
      rb_sat = -8'sd128;
    end else begin
      rb_sat = rb_w[7:0];
    end
    if (sft > 7'sd0) begin
      nx = rnd_right(s3.base.x, 5'(sft - 7'sd1));
      ny = rnd_right(s3.base.y, 5'(sft - 7'sd1));
    end else begin
      nx = shl16(s3.base.x[15:0], 5'(-sft));
      ny = shl16(s3.base.y[15:0], 5'(-sft));
    end

    r_x_next      = '0;
    r_y_next      = '0;
    r_bbp_next    = '0;
    is_equal_next = 1'b0;
    case (s3.base.kind)
      K_ADDSUB, K_SCALE: begin
        if (!s3.zero) begin
          r_x_next   = nx;
          r_y_next   = ny;
          r_bbp_next = rb_sat;
        end
      end
      K_EQUAL: begin
        is_equal_next = s3.base.eq;
      end
      K_CONVERT: begin
        r_x_next   = s3.base.x[15:0];
        r_y_next   = s3.base.y[15:0];
        r_bbp_next = s3.base.bbp[7:0];
      end
      default: begin
        is_equal_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (adv1) v1 <= !q_empty;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv_o) vo <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) s1 <= s1_next;
    if (adv2) s2 <= s2_next;
    if (adv3) s3 <= s3_next;
    if (adv_o) begin
      r_x      <= r_x_next;
      r_y      <= r_y_next;
      r_bbp    <= r_bbp_next;
      is_equal <= is_equal_next;
    end
  end

  assign rsp.valid    = vo;
  assign rsp.r_x      = r_x;
  assign rsp.r_y      = r_y;
  assign rsp.r_bbp    = r_bbp;
  assign rsp.is_equal = is_equal;

endmodule

// File: sv/block_float_vec2_alu_unit.sv
// Top level of the block floating point vector ALU: front, queue and back.
// Depends on bfv_pkg, bfv_req_if, bfv_rsp_if, bfv_front, bfv_queue, bfv_back.
//
// This unit does add, subtract, scale, equality test and convert-to-fixed on
// 2D vectors whose two 16-bit mantissas share one binary point position. It
// takes one request transaction per clock cycle while its queue is not full,
// and returns one response transaction per request, in order. A response
// passes through the two-entry queue, during which the arithmetic works on
// the queue output, then magnitude, MSB search, and the renormalizing
// output register. The sustained rate of one transaction per cycle, while
// the response side is ready, is set by the back pipeline, whose stages each
// take a new transaction every cycle; the queue's spare entry lets the front
// accept one more request while the response side stalls. Unused request
// codes return all-zero fields.
module block_float_vec2_alu_unit
  import bfv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bfv_req_if.sink   req,
  bfv_rsp_if.source rsp
);

  q_stat_t qstat;
  logic    push;
  logic    pop;
  dec_t    dec_in;
  dec_t    dec_out;

  // The front classifies a request and picks which operand gets aligned.
  bfv_front u_front (
    .req   (req),
    .qstat (qstat),
    .push  (push),
    .dec   (dec_in)
  );

  // The queue decouples acceptance from execution.
  bfv_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (dec_in),
    .pop  (pop),
    .dout (dec_out),
    .stat (qstat)
  );

  // The back computes, renormalizes and presents the response.
  bfv_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (qstat.empty),
    .pop     (pop),
    .dec     (dec_out),
    .rsp     (rsp)
  );

`ifndef SYNTHESIS
  a_eq_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_equal) |->
    (rsp.r_x == 16'sd0 && rsp.r_y == 16'sd0 && rsp.r_bbp == 8'sd0))
    else $error("equality response carries nonzero mantissa or bbp");

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty at once");

  a_reset_clean: assert property (@(posedge clk)
    $past(rst) |-> (qstat.empty && !rsp.valid))
    else $error("queue or response not cleared by reset");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for block_float_vec2_alu_unit: queue-fed driver, monitor, predictor.
// Depends on bfv_pkg, bfv_req_if, bfv_rsp_if and the unit itself.
module tb_top;
  import bfv_pkg::*;

  // Request codes five to seven are not assigned and must give all-zero results.
  localparam int UNUSED_FIRST = 5;
  localparam int UNUSED_LAST  = 7;

  localparam int RANDOM_ITEMS   = 1925;
  localparam int IDLE_PCT       = 17;
  // Both sides run without gaps while their transaction count sits in this window.
  localparam int CALM_LO        = 700;
  localparam int CALM_HI        = 1000;
  // The response side holds off once, long enough to fill the queue and the pipeline.
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 80;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    logic [2:0]         op;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [7:0]  a_bbp;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [7:0]  b_bbp;
  } vec_req_t;

  typedef struct {
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [7:0]  r_bbp;
    logic               is_equal;
  } vec_rsp_t;

  logic clk;
  logic rst;

  bfv_req_if req_ch ();
  bfv_rsp_if rsp_ch ();

  block_float_vec2_alu_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Requests still to be offered, and the results predicted for accepted requests.
  vec_req_t pending_reqs[$];
  vec_rsp_t expected_rsps[$];

  int  total_items;
  int  sent_count;
  int  rsp_count;
  int  error_count;
  int  stall_cycles;
  int  hold_left;
  bit  hold_done;
  bit  req_taken;
  bit  drained;
  int  op_hits[8];

  // ------------------------------------------------------------------
  // Clock and reset. Reset is released at a falling edge, so the first
  // transaction is offered cleanly.
  // ------------------------------------------------------------------
  always #1 clk = ~clk;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = '0;
    req_ch.a_x      = '0;
    req_ch.a_y      = '0;
    req_ch.a_bbp    = '0;
    req_ch.b_x      = '0;
    req_ch.b_y      = '0;
    req_ch.b_bbp    = '0;
    rsp_ch.ready    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // ------------------------------------------------------------------
  // Predictor. All arithmetic is carried in 64-bit signed integers, and
  // 32-bit wraparound is applied explicitly where the datapath wraps.
  // ------------------------------------------------------------------
  function automatic longint wrap32(longint v);
    logic signed [31:0] w;
    w = v[31:0];
    return longint'(w);
  endfunction

  function automatic longint shl32(longint v, int unsigned n);
    return wrap32(v << n);
  endfunction

  function automatic int unsigned clamp31(longint d);
    return (d > 31) ? 31 : int'(d);
  endfunction

  function automatic logic signed [7:0] sat_bbp(longint v);
    if (v > 127) return 8'sd127;
    if (v < -128) return -8'sd128;
    return v[7:0];
  endfunction

  function automatic logic signed [15:0] low16(longint v);
    return v[15:0];
  endfunction

  // Right shifts round half up; a non-positive amount is a plain left shift.
  function automatic longint round_shift(longint v, longint s);
    if (s > 0) return ((v >>> (s - 1)) + 1) >>> 1;
    return v <<< (-s);
  endfunction

  // Brings the larger magnitude's MSB to NORM_MSB; a zero vector is all zero.
  function automatic vec_rsp_t renormalize(longint x, longint y, longint bbp);
    vec_rsp_t res;
    longint   mx;
    longint   my;
    longint   m;
    longint   s;
    int       msb;
    res = '{r_x: '0, r_y: '0, r_bbp: '0, is_equal: 1'b0};
    if (x == 0 && y == 0) return res;
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    m = (mx > my) ? mx : my;
    msb = 0;
    for (int i = 32; i >= 0; i--) begin
      if (m[i]) begin
        msb = i;
        break;
      end
    end
    s = msb - NORM_MSB;
    res.r_x = low16(round_shift(x, s));
    res.r_y = low16(round_shift(y, s));
    res.r_bbp = sat_bbp(bbp - s);
    return res;
  endfunction

  function automatic vec_rsp_t predict_vec_result(vec_req_t r);
    vec_rsp_t    res;
    longint      ax;
    longint      ay;
    longint      abp;
    longint      bx;
    longint      by;
    longint      bbp;
    longint      d;
    longint      sx;
    longint      sy;
    longint      x;
    longint      y;
    int unsigned s;
    res = '{r_x: '0, r_y: '0, r_bbp: '0, is_equal: 1'b0};
    ax = r.a_x;
    ay = r.a_y;
    abp = r.a_bbp;
    bx = r.b_x;
    by = r.b_y;
    bbp = r.b_bbp;
    d = abp - bbp;
    case (r.op)
      REQ_ADD, REQ_SUB: begin
        // The operand with the smaller bbp is shifted up to the larger one.
        if (d > 0) begin
          s = clamp31(d);
          sx = shl32(bx, s);
          sy = shl32(by, s);
          x = (r.op == REQ_ADD) ? wrap32(sx + ax) : wrap32(ax - sx);
          y = (r.op == REQ_ADD) ? wrap32(sy + ay) : wrap32(ay - sy);
          res = renormalize(x, y, abp);
        end else begin
          s = clamp31(-d);
          sx = shl32(ax, s);
          sy = shl32(ay, s);
          x = (r.op == REQ_ADD) ? wrap32(sx + bx) : wrap32(sx - bx);
          y = (r.op == REQ_ADD) ? wrap32(sy + by) : wrap32(sy - by);
          res = renormalize(x, y, bbp);
        end
      end
      REQ_SCALE: begin
        res = renormalize(ax * bx, ay * bx, abp + bbp);
      end
      REQ_EQUAL: begin
        if (d == 0) begin
          res.is_equal = (ax == bx) && (ay == by);
        end else if (d > 0) begin
          s = clamp31(d);
          sx = shl32(bx, s);
          sy = shl32(by, s);
          res.is_equal = (ax == sx) && (ay == sy) && ((sx >>> s) == bx) && ((sy >>> s) == by);
        end else begin
          s = clamp31(-d);
          sx = shl32(ax, s);
          sy = shl32(ay, s);
          res.is_equal = (bx == sx) && (by == sy) && ((sx >>> s) == ax) && ((sy >>> s) == ay);
        end
      end
      REQ_CONVERT: begin
        if (d > 0) begin
          s = clamp31(d);
          res.r_x = low16(round_shift(ax, s));
          res.r_y = low16(round_shift(ay, s));
        end else begin
          s = clamp31(-d);
          res.r_x = low16(shl32(ax, s));
          res.r_y = low16(shl32(ay, s));
        end
        res.r_bbp = r.b_bbp;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus generation.
  // ------------------------------------------------------------------
  task automatic queue_req(logic [2:0] op, int ax, int ay, int abp, int bx, int by, int bbp);
    vec_req_t r;
    r.op = op;
    r.a_x = 16'(ax);
    r.a_y = 16'(ay);
    r.a_bbp = 8'(abp);
    r.b_x = 16'(bx);
    r.b_y = 16'(by);
    r.b_bbp = 8'(bbp);
    pending_reqs.push_back(r);
  endtask

  // Mantissas mix full-range noise with small values, extremes and powers of two.
  function automatic logic signed [15:0] rand_mant();
    logic signed [15:0] p;
    case ($urandom_range(0, 7))
      3: return 16'(int'($urandom_range(0, 64)) - 32);
      4: begin
        case ($urandom_range(0, 4))
          0: return 16'sd32767;
          1: return -16'sd32768;
          2: return 16'sd0;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      5: begin
        p = 16'sd1 <<< $urandom_range(0, 15);
        if ($urandom_range(0, 1) == 1) p = -p;
        return p;
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vec_req_t rand_req();
    vec_req_t           r;
    vec_req_t           t;
    int                 d;
    int                 lim;
    int                 bb;
    r.a_x = rand_mant();
    r.a_y = rand_mant();
    r.b_x = rand_mant();
    r.b_y = rand_mant();
    r.a_bbp = 8'($urandom);
    // Most bbp pairs lie close together, so the shifted operand still matters.
    if ($urandom_range(0, 9) < 6) r.b_bbp = 8'(int'(r.a_bbp) + int'($urandom_range(0, 40)) - 20);
    else r.b_bbp = 8'($urandom);
    if ($urandom_range(0, 99) < 4) begin
      r.op = 3'($urandom_range(UNUSED_FIRST, UNUSED_LAST));
    end else begin
      r.op = 3'($urandom_range(REQ_ADD, REQ_CONVERT));
    end
    // Half of the equality tests are built to match, some then spoiled by one bit.
    if (r.op == REQ_EQUAL && $urandom_range(0, 1) == 1) begin
      d = $urandom_range(0, 8);
      lim = 1 << (15 - d);
      bb = int'($urandom_range(0, 200)) - 100;
      r.b_x = 16'(int'($urandom_range(0, 2 * lim - 1)) - lim);
      r.b_y = 16'(int'($urandom_range(0, 2 * lim - 1)) - lim);
      r.b_bbp = 8'(bb);
      r.a_x = r.b_x <<< d;
      r.a_y = r.b_y <<< d;
      r.a_bbp = 8'(bb + d);
      if ($urandom_range(0, 4) == 0) r.a_x = r.a_x ^ (16'sd1 <<< $urandom_range(0, 15));
      if ($urandom_range(0, 1) == 1) begin
        t = r;
        r.a_x = t.b_x;
        r.a_y = t.b_y;
        r.a_bbp = t.b_bbp;
        r.b_x = t.a_x;
        r.b_y = t.a_y;
        r.b_bbp = t.a_bbp;
      end
    end
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Request driver. The offered transaction is held until the monitor
  // sees it accepted; a new one is offered or the line idles at random.
  // Every signal gets a single nonblocking update per falling edge.
  // ------------------------------------------------------------------
  vec_req_t held_req;

  always @(negedge clk) begin : drive_req
    logic next_valid;
    logic calm;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      next_valid = req_ch.valid && !req_taken;
      calm = (sent_count >= CALM_LO) && (sent_count < CALM_HI);
      if (!next_valid && pending_reqs.size() != 0 &&
          (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        held_req = pending_reqs.pop_front();
        next_valid = 1'b1;
      end
    end
    req_ch.valid    <= next_valid;
    req_ch.req_type <= held_req.op;
    req_ch.a_x      <= held_req.a_x;
    req_ch.a_y      <= held_req.a_y;
    req_ch.a_bbp    <= held_req.a_bbp;
    req_ch.b_x      <= held_req.b_x;
    req_ch.b_y      <= held_req.b_y;
    req_ch.b_bbp    <= held_req.b_bbp;
  end

  // ------------------------------------------------------------------
  // Response ready. Random gaps, a calm window, and one long hold-off
  // that backs the unit up until its input stalls.
  // ------------------------------------------------------------------
  always @(negedge clk) begin : drive_ready
    logic next_ready;
    if (rst) begin
      next_ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      next_ready = 1'b0;
    end else if (!hold_done && rsp_count >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      next_ready = 1'b0;
    end else if (rsp_count >= CALM_LO && rsp_count < CALM_HI) begin
      next_ready = 1'b1;
    end else begin
      next_ready = ($urandom_range(0, 99) >= IDLE_PCT);
    end
    rsp_ch.ready <= next_ready;
  end

  // ------------------------------------------------------------------
  // Monitor and watchdog, at the rising edge. An accepted request pushes
  // its predicted result; an accepted response is checked against the
  // oldest prediction. A long run of cycles with no transaction on
  // either side ends the run as a failure.
  // ------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    vec_req_t seen;
    vec_rsp_t want;
    bit       rsp_taken;
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      req_taken = req_ch.valid && req_ch.ready;
      rsp_taken = rsp_ch.valid && rsp_ch.ready;
      if (rsp_taken) begin
        rsp_count++;
        if (expected_rsps.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("ERROR: response with nothing expected: x=%0d y=%0d bbp=%0d eq=%0b",
                     rsp_ch.r_x, rsp_ch.r_y, rsp_ch.r_bbp, rsp_ch.is_equal);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_ch.r_x !== want.r_x || rsp_ch.r_y !== want.r_y ||
              rsp_ch.r_bbp !== want.r_bbp || rsp_ch.is_equal !== want.is_equal) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
              $display("ERROR: result %0d: expected x=%0d y=%0d bbp=%0d eq=%0b, got x=%0d y=%0d bbp=%0d eq=%0b",
                       rsp_count, want.r_x, want.r_y, want.r_bbp, want.is_equal,
                       rsp_ch.r_x, rsp_ch.r_y, rsp_ch.r_bbp, rsp_ch.is_equal);
          end
        end
      end
      if (req_taken) begin
        seen.op = req_ch.req_type;
        seen.a_x = req_ch.a_x;
        seen.a_y = req_ch.a_y;
        seen.a_bbp = req_ch.a_bbp;
        seen.b_x = req_ch.b_x;
        seen.b_y = req_ch.b_y;
        seen.b_bbp = req_ch.b_bbp;
        expected_rsps.push_back(predict_vec_result(seen));
        op_hits[seen.op]++;
        sent_count++;
      end
      stall_cycles = (req_taken || rsp_taken) ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_rsps.size());
        $display("Simulation FAILED");
        $finish;
      end
      drained = (total_items != 0) && (sent_count == total_items) && (expected_rsps.size() == 0);
    end
  end

  // ------------------------------------------------------------------
  // Test sequence: directed corners first, then random requests. The
  // run ends once every request is accepted and every result checked.
  // ------------------------------------------------------------------
  initial begin
    // Extreme mantissas with saturated alignment in both directions.
    queue_req(REQ_ADD, 32767, -32768, 127, -32768, 32767, -128);
    queue_req(REQ_ADD, 32767, 32767, -128, 32767, 32767, 127);
    queue_req(REQ_ADD, -1, -1, 20, 32767, -32768, 0);
    // Sums that cancel give the all-zero result.
    queue_req(REQ_ADD, 5, -7, 3, -5, 7, 3);
    queue_req(REQ_SUB, -32768, 32767, 0, -32768, 32767, 0);
    // Largest difference, and a sum that needs a rounded right shift.
    queue_req(REQ_SUB, -32768, -32768, 0, 32767, 32767, 0);
    queue_req(REQ_ADD, 16385, 3, 0, 16384, 0, 0);
    // Tiny sum that is shifted left during renormalization.
    queue_req(REQ_ADD, 1, 0, 10, 0, 0, 10);
    // Scale: largest product with bbp saturating high, and low.
    queue_req(REQ_SCALE, -32768, -32768, 127, -32768, 0, 127);
    queue_req(REQ_SCALE, 1, -1, -128, 1, 0, -128);
    queue_req(REQ_SCALE, 1234, -4321, 5, 0, 0, 7);
    queue_req(REQ_SCALE, 32767, -32768, 0, -1, 0, 0);
    // Equality at equal bbp, with the smaller bbp on either side, and saturated.
    queue_req(REQ_EQUAL, 100, -100, 4, 100, -100, 4);
    queue_req(REQ_EQUAL, 100, -100, 4, 100, -99, 4);
    queue_req(REQ_EQUAL, 8, -8, 2, 2, -2, 0);
    queue_req(REQ_EQUAL, 2, -2, 0, 8, -8, 2);
    queue_req(REQ_EQUAL, 0, 0, 127, 0, 0, -128);
    queue_req(REQ_EQUAL, 0, 0, 127, 1, 0, -128);
    // Convert: half-way rounding, saturated right and left shifts, no shift.
    queue_req(REQ_CONVERT, 3, -3, 1, 0, 0, 0);
    queue_req(REQ_CONVERT, -32768, 32767, 127, 0, 0, -128);
    queue_req(REQ_CONVERT, 32767, -32768, -128, 0, 0, 127);
    queue_req(REQ_CONVERT, -1, 1, 5, 0, 0, 5);
    // Unassigned request codes.
    for (int c = UNUSED_FIRST; c <= UNUSED_LAST; c++)
      queue_req(3'(c), -32768, 32767, 127, -1, 1, -128);
    for (int i = 0; i < RANDOM_ITEMS; i++)
      pending_reqs.push_back(rand_req());
    total_items = pending_reqs.size();

    wait (rst == 1'b0);
    wait (drained);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results of %0d requests: add %0d, sub %0d, scale %0d, equal %0d, convert %0d, unused %0d.",
             rsp_count, sent_count, op_hits[REQ_ADD], op_hits[REQ_SUB], op_hits[REQ_SCALE],
             op_hits[REQ_EQUAL], op_hits[REQ_CONVERT],
             op_hits[5] + op_hits[6] + op_hits[7]);
    $display("Random gaps on both sides, a gap-free window and one %0d-cycle response hold-off; %0d errors.",
             HOLD_CYCLES, error_count);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
